@@ rtl/cpu4r_pkg.sv @@
// Shared types, constants and helpers for the four-register 8-bit core step block.
// Used by cpu4r_alu, cpu4r_ram, cpu4r_checker and the top level; depends on nothing else.
package cpu4r_pkg;

  localparam int DATA_W    = 8;
  localparam int NUM_REGS  = 4;
  localparam int REG_IDX_W = $clog2(NUM_REGS);

  // Data RAM geometry; the depth may range from 16 to 256 entries.
  localparam int RAM_DEPTH  = 256;
  localparam int RAM_ADDR_W = $clog2(RAM_DEPTH);

  typedef logic [DATA_W-1:0] data_t;
  typedef data_t [NUM_REGS-1:0] regs_t;

  // Opcode field, bits 7:4 of the instruction byte.
  typedef enum logic [3:0] {
    OP_MOV  = 4'h0,
    OP_ADD  = 4'h1,
    OP_SUB  = 4'h2,
    OP_AND  = 4'h3,
    OP_OR   = 4'h4,
    OP_NOT  = 4'h5,
    OP_SHL  = 4'h6,
    OP_SHR  = 4'h7,
    OP_SHR2 = 4'h8,
    OP_CMP  = 4'h9,
    OP_BRF  = 4'ha,
    OP_JMP  = 4'hb,
    OP_LIH  = 4'hc,
    OP_LIL  = 4'hd,
    OP_LD   = 4'he,
    OP_ST   = 4'hf
  } op_e;

  // Machine state after one instruction, plus its RAM write.
  typedef struct packed {
    regs_t regs;
    data_t pc;
    logic  flag;
    logic  st_done;
    data_t st_addr;
    data_t st_data;
  } exec_res_t;

  // True when a byte address falls inside the data RAM.
  function automatic logic addr_in_range(data_t addr);
    return {1'b0, addr} < (DATA_W + 1)'(RAM_DEPTH);
  endfunction

endpackage

@@ rtl/eight_bit_four_register_cpu_step_top.sv @@
// Top level of the four-register 8-bit core step block.
// Depends on cpu4r_pkg, cpu4r_alu and cpu4r_ram.
//
// Each input item is one instruction byte fetched at the current program
// counter. Each accepted item yields exactly one result item: the new program
// counter, all four registers, the compare flag and the RAM write, if any.
// Both channels use valid and stall; an item moves on a rising edge where
// valid is high and stall is low.
//
// An accepted item goes to the input stage, then to the result register. The
// block sustains one item per cycle while the receiver does not stall: the data
// RAM read for a load is issued in the acceptance cycle, its address forwarded
// from the executing instruction, so the combinational execute path sets the rate.
//
// Reset clears the registers, program counter, flag and every RAM valid bit,
// so the whole RAM reads as zero at once; no clearing pass is needed.
// When the receiver stalls, the result holds steady and one further item is
// taken into the input stage; after that, the input stalls as well.
module eight_bit_four_register_cpu_step_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  cpu4r_pkg::data_t instruction_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output cpu4r_pkg::data_t next_pc_o,
  output cpu4r_pkg::data_t r0_value_o,
  output cpu4r_pkg::data_t r1_value_o,
  output cpu4r_pkg::data_t r2_value_o,
  output cpu4r_pkg::data_t r3_value_o,
  output logic             cmp_flag_o,
  output logic             store_done_o,
  output cpu4r_pkg::data_t store_addr_o,
  output cpu4r_pkg::data_t store_data_o
);
  import cpu4r_pkg::*;

  logic      in_accept;
  logic      ex_fire;
  logic      stg_valid_q;
  data_t     instr_q;
  regs_t     regs_q;
  regs_t     regs_d;
  data_t     pc_q;
  logic      flag_q;
  logic      out_valid_q;
  logic      st_done_q;
  data_t     st_addr_q;
  data_t     st_data_q;
  data_t     load_data;
  data_t     rd_addr;
  exec_res_t res;

  // Handshake: execute when the result slot is free or being emptied.
  assign ex_fire    = stg_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = stg_valid_q && !ex_fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Register values as they stand after this cycle, for the load address.
  assign regs_d  = ex_fire ? res.regs : regs_q;
  assign rd_addr = regs_d[instruction_i[1:0]];

  cpu4r_alu u_alu (
    .instr_i     (instr_q),
    .regs_i      (regs_q),
    .pc_i        (pc_q),
    .flag_i      (flag_q),
    .load_data_i (load_data),
    .res_o       (res)
  );

  cpu4r_ram u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_accept),
    .rd_addr_i (rd_addr),
    .wr_en_i   (ex_fire && res.st_done),
    .wr_addr_i (res.st_addr),
    .wr_data_i (res.st_data),
    .rd_data_o (load_data)
  );

  // Input stage holding the instruction that executes next.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      instr_q <= instruction_i;
    end
  end

  // Architectural state and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      regs_q      <= '0;
      pc_q        <= '0;
      flag_q      <= 1'b0;
      st_done_q   <= 1'b0;
      st_addr_q   <= '0;
      st_data_q   <= '0;
    end else begin
      if (in_accept) begin
        stg_valid_q <= 1'b1;
      end else if (ex_fire) begin
        stg_valid_q <= 1'b0;
      end
      if (ex_fire) begin
        out_valid_q <= 1'b1;
        regs_q      <= res.regs;
        pc_q        <= res.pc;
        flag_q      <= res.flag;
        st_done_q   <= res.st_done;
        st_addr_q   <= res.st_addr;
        st_data_q   <= res.st_data;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The state only changes when a new result is loaded, so it is the payload.
  assign out_valid_o  = out_valid_q;
  assign next_pc_o    = pc_q;
  assign r0_value_o   = regs_q[0];
  assign r1_value_o   = regs_q[1];
  assign r2_value_o   = regs_q[2];
  assign r3_value_o   = regs_q[3];
  assign cmp_flag_o   = flag_q;
  assign store_done_o = st_done_q;
  assign store_addr_o = st_addr_q;
  assign store_data_o = st_data_q;

endmodule

@@ rtl/cpu4r_alu.sv @@
// Combinational execute logic for one instruction of the four-register core.
// Depends on cpu4r_pkg for the opcode set, register types and the RAM range check.
module cpu4r_alu (
  input  cpu4r_pkg::data_t     instr_i,
  input  cpu4r_pkg::regs_t     regs_i,
  input  cpu4r_pkg::data_t     pc_i,
  input  logic                 flag_i,
  input  cpu4r_pkg::data_t     load_data_i,
  output cpu4r_pkg::exec_res_t res_o
);
  import cpu4r_pkg::*;

  op_e                  op;
  logic [REG_IDX_W-1:0] rd;
  logic [REG_IDX_W-1:0] rs;
  logic [3:0]           imm;
  data_t                a;
  data_t                b;
  data_t                shl_val;
  data_t                shr_val;
  data_t                pc_inc;

  assign op     = op_e'(instr_i[7:4]);
  assign rd     = instr_i[3:2];
  assign rs     = instr_i[1:0];
  assign imm    = instr_i[3:0];
  assign a      = regs_i[rd];
  assign b      = regs_i[rs];
  assign pc_inc = pc_i + data_t'(1);

  // Shifts by eight or more clear the register.
  assign shl_val = (b[DATA_W-1:3] != '0) ? '0 : (a << b[2:0]);
  assign shr_val = (b[DATA_W-1:3] != '0) ? '0 : (a >> b[2:0]);

  // Apply the opcode to a copy of the architectural state.
  always_comb begin
    res_o         = '0;
    res_o.regs    = regs_i;
    res_o.pc      = pc_inc;
    res_o.flag    = flag_i;
    unique case (op)
      OP_MOV:  res_o.regs[rd] = b;
      OP_ADD:  res_o.regs[rd] = a + b;
      OP_SUB:  res_o.regs[rd] = a - b;
      OP_AND:  res_o.regs[rd] = a & b;
      OP_OR:   res_o.regs[rd] = a | b;
      OP_NOT:  res_o.regs[rd] = ~b;
      OP_SHL:  res_o.regs[rd] = shl_val;
      OP_SHR:  res_o.regs[rd] = shr_val;
      OP_SHR2: res_o.regs[rd] = shr_val;
      OP_CMP:  res_o.flag = (a == b);
      OP_BRF: begin
        if (flag_i) begin
          res_o.pc   = b;
          res_o.flag = 1'b0;
        end
      end
      OP_JMP:  res_o.pc = b;
      OP_LIH:  res_o.regs[NUM_REGS-1] = regs_i[NUM_REGS-1] | {imm, 4'h0};
      OP_LIL:  res_o.regs[NUM_REGS-1] = {4'h0, imm};
      OP_LD:   res_o.regs[rd] = load_data_i;
      OP_ST: begin
        if (addr_in_range(b)) begin
          res_o.st_done = 1'b1;
          res_o.st_addr = b;
          res_o.st_data = a;
        end
      end
    endcase
  end

endmodule

@@ rtl/cpu4r_ram.sv @@
// Data RAM with per-entry valid bits so that unwritten entries read as zero after reset.
// Depends on cpu4r_pkg for the depth, the data type and the range check.
module cpu4r_ram (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  cpu4r_pkg::data_t rd_addr_i,
  input  logic             wr_en_i,
  input  cpu4r_pkg::data_t wr_addr_i,
  input  cpu4r_pkg::data_t wr_data_i,
  output cpu4r_pkg::data_t rd_data_o
);
  import cpu4r_pkg::*;

  data_t                 mem [RAM_DEPTH];
  logic [RAM_DEPTH-1:0]  valid_q;
  logic [RAM_ADDR_W-1:0] rd_idx;
  logic [RAM_ADDR_W-1:0] wr_idx;
  logic                  wr_ok;
  data_t                 mem_q;
  logic                  hit_q;
  logic                  fwd_q;
  data_t                 fwd_data_q;

  assign rd_idx = rd_addr_i[RAM_ADDR_W-1:0];
  assign wr_idx = wr_addr_i[RAM_ADDR_W-1:0];
  assign wr_ok  = wr_en_i && addr_in_range(wr_addr_i);

  // Storage array: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      mem[wr_idx] <= wr_data_i;
    end
    if (rd_en_i) begin
      mem_q      <= mem[rd_idx];
      fwd_data_q <= wr_data_i;
    end
  end

  // Valid bits and read qualifiers; a write in the read cycle is forwarded.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      hit_q   <= 1'b0;
      fwd_q   <= 1'b0;
    end else begin
      if (wr_ok) begin
        valid_q[wr_idx] <= 1'b1;
      end
      if (rd_en_i) begin
        hit_q <= addr_in_range(rd_addr_i) && valid_q[rd_idx];
        fwd_q <= wr_ok && (wr_addr_i == rd_addr_i);
      end
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : (hit_q ? mem_q : '0);

endmodule

@@ rtl/cpu4r_checker.sv @@
// Port-level checks for the four-register core step block, bound to its top level.
// Depends on cpu4r_pkg for the data type.
module cpu4r_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input cpu4r_pkg::data_t next_pc_o,
  input cpu4r_pkg::data_t r3_value_o,
  input logic             store_done_o,
  input cpu4r_pkg::data_t store_addr_o,
  input cpu4r_pkg::data_t store_data_o
);
  import cpu4r_pkg::*;

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(next_pc_o)
      && $stable(r3_value_o) && $stable(store_addr_o))
    else $error("stalled result item changed");

  // Without a store, the store fields read zero.
  a_no_store_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !store_done_o |-> store_addr_o == '0 && store_data_o == '0)
    else $error("store fields nonzero without a store");

  // The input only stalls while a result waits on a stalled receiver.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with the result side free");

  // An item taken while the output is empty reaches the result register unless the receiver stalls.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !out_valid_o) ##1 !out_stall_i |=> out_valid_o)
    else $error("result item missing after accepted item");

endmodule

bind eight_bit_four_register_cpu_step_top cpu4r_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .next_pc_o    (next_pc_o),
  .r3_value_o   (r3_value_o),
  .store_done_o (store_done_o),
  .store_addr_o (store_addr_o),
  .store_data_o (store_data_o)
);
